// ===== rtl/core/obav_pkg.sv =====
// Shared types, codes and constants of the obstacle-avoiding navigation controller.
package obav_pkg;

   typedef enum logic [2:0] {
      MODE_INIT      = 3'd0,
      MODE_WAIT      = 3'd1,
      MODE_NAV       = 3'd2,
      MODE_OBS_R     = 3'd3,
      MODE_OBS_L     = 3'd4,
      MODE_MID_FAR   = 3'd5,
      MODE_MID_CLOSE = 3'd6,
      MODE_PAUSE     = 3'd7
   } nav_mode_type;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } motor_dir_type;

   typedef enum logic [3:0] {
      CSR_STEER_THRESHOLD = 4'd0,
      CSR_MIDDLE_FAR      = 4'd1,
      CSR_MIDDLE_CLOSE    = 4'd2,
      CSR_REVERSE_LIMIT   = 4'd3,
      CSR_PAUSE_TICKS     = 4'd4,
      CSR_ARRIVE_DISTANCE = 4'd5,
      CSR_HEADING_DB      = 4'd6,
      CSR_AVOID_STEER     = 4'd7
   } csr_index_type;

   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned REQ_DATA_W   = 112;
   localparam int unsigned RSP_DATA_W   = 24;

   localparam logic [7:0] SPEED_OBS     = 8'd125;
   localparam logic [7:0] SPEED_REV     = 8'd50;
   localparam logic [5:0] STEER_MAX_DEG = 6'd45;

   // floor(x / 80) == (x * RECIP_80) >> RECIP_SHIFT for every 16-bit x.
   localparam logic [15:0] RECIP_80     = 16'd52429;
   localparam int unsigned RECIP_SHIFT  = 22;

   typedef struct packed {
      logic        go_enable;
      logic [31:0] tick_count;
      logic [9:0]  left_range_cm;
      logic [9:0]  right_range_cm;
      logic [9:0]  middle_range_cm;
      logic [9:0]  rear_range_cm;
      logic        left_bumper_open;
      logic        right_bumper_open;
      logic signed [15:0] heading_error_cdeg;
      logic [15:0] waypoint_distance_dm;
   } req_type;

   typedef struct packed {
      logic [9:0]  side_limit_cm;
      logic [9:0]  middle_far_cm;
      logic [9:0]  middle_close_cm;
      logic [9:0]  reverse_limit_cm;
      logic [15:0] pause_ticks;
      logic [15:0] arrive_distance_dm;
      logic [14:0] heading_deadband_cdeg;
      logic [5:0]  avoid_steer_deg;
   } cfg_type;

   typedef struct packed {
      logic signed [6:0] steer_deg;
      logic [7:0]        speed_centi;
   } nav_steer_type;

   typedef struct packed {
      motor_dir_type     motor_dir;
      logic [7:0]        motor_speed_centi;
      logic signed [6:0] steer_deg;
      nav_mode_type      mode_now;
   } cmd_type;

   // Navigate speed 200*(90-a)/90, truncated, for steer magnitude a in 0..45.
   function automatic logic [7:0] speed_for_steer(input logic [5:0] amag);
      logic [7:0] spd;
      case (amag)
         6'd0:  spd = 8'd200;  6'd1:  spd = 8'd197;  6'd2:  spd = 8'd195;
         6'd3:  spd = 8'd193;  6'd4:  spd = 8'd191;  6'd5:  spd = 8'd188;
         6'd6:  spd = 8'd186;  6'd7:  spd = 8'd184;  6'd8:  spd = 8'd182;
         6'd9:  spd = 8'd180;  6'd10: spd = 8'd177;  6'd11: spd = 8'd175;
         6'd12: spd = 8'd173;  6'd13: spd = 8'd171;  6'd14: spd = 8'd168;
         6'd15: spd = 8'd166;  6'd16: spd = 8'd164;  6'd17: spd = 8'd162;
         6'd18: spd = 8'd160;  6'd19: spd = 8'd157;  6'd20: spd = 8'd155;
         6'd21: spd = 8'd153;  6'd22: spd = 8'd151;  6'd23: spd = 8'd148;
         6'd24: spd = 8'd146;  6'd25: spd = 8'd144;  6'd26: spd = 8'd142;
         6'd27: spd = 8'd140;  6'd28: spd = 8'd137;  6'd29: spd = 8'd135;
         6'd30: spd = 8'd133;  6'd31: spd = 8'd131;  6'd32: spd = 8'd128;
         6'd33: spd = 8'd126;  6'd34: spd = 8'd124;  6'd35: spd = 8'd122;
         6'd36: spd = 8'd120;  6'd37: spd = 8'd117;  6'd38: spd = 8'd115;
         6'd39: spd = 8'd113;  6'd40: spd = 8'd111;  6'd41: spd = 8'd108;
         6'd42: spd = 8'd106;  6'd43: spd = 8'd104;  6'd44: spd = 8'd102;
         6'd45: spd = 8'd100;
         default: spd = 8'd100;
      endcase
      return spd;
   endfunction

endpackage

// ===== rtl/core/obav_steer.sv =====
// Heading-following steer angle and navigate speed.
module obav_steer (
   input  logic signed [15:0]     heading_error_cdeg,
   input  logic [14:0]            heading_deadband_cdeg,
   output obav_pkg::nav_steer_type nav_out
);
   import obav_pkg::*;

   logic [15:0] mag;
   logic [31:0] prod;
   logic [9:0]  quot;
   logic        over_db;
   logic [5:0]  amag;

   // Magnitude is unsigned, so the most negative heading gives 32768 correctly.
   assign mag     = heading_error_cdeg[15] ? 16'(~heading_error_cdeg + 16'sd1)
                                           : heading_error_cdeg;
   assign prod    = 32'(mag) * 32'(RECIP_80);
   assign quot    = prod[RECIP_SHIFT +: 10];
   assign over_db = mag > 16'(heading_deadband_cdeg);

   always_comb begin
      if (!over_db) begin
         amag = 6'd0;
      end else if (quot > 10'(STEER_MAX_DEG)) begin
         amag = STEER_MAX_DEG;
      end else begin
         amag = quot[5:0];
      end
   end

   assign nav_out.steer_deg   = heading_error_cdeg[15] ? -$signed({1'b0, amag})
                                                       : $signed({1'b0, amag});
   assign nav_out.speed_centi = speed_for_steer(amag);

endmodule

// ===== rtl/core/obav_fsm.sv =====
// Navigation mode state machine, pause timer and motor command selection.
module obav_fsm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv_en,
   input  obav_pkg::req_type         item,
   input  obav_pkg::cfg_type         cfg,
   input  obav_pkg::nav_steer_type   nav_in,
   output obav_pkg::cmd_type         cmd
);
   import obav_pkg::*;

   nav_mode_type  mode_ff, mode_in;
   logic [31:0]   pause_start_ff, pause_start_in;
   nav_mode_type  side_mode, front_mode;
   logic          bump, stop_req, close_front, pause_done;
   logic [5:0]    avoid;
   logic [31:0]   pause_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_INIT;
         pause_start_ff <= '0;
      end else if (adv_en) begin
         mode_ff        <= mode_in;
         pause_start_ff <= pause_start_in;
      end
   end

   assign bump        = !item.left_bumper_open || !item.right_bumper_open;
   assign stop_req    = !item.go_enable || (item.waypoint_distance_dm < cfg.arrive_distance_dm);
   assign close_front = item.middle_range_cm < cfg.middle_close_cm;
   assign avoid       = (cfg.avoid_steer_deg > STEER_MAX_DEG) ? STEER_MAX_DEG
                                                              : cfg.avoid_steer_deg;
   assign pause_end   = pause_start_ff + 32'(cfg.pause_ticks);
   assign pause_done  = item.tick_count > pause_end;

   always_comb begin
      if (item.left_range_cm < cfg.side_limit_cm) begin
         side_mode = (item.right_range_cm <= item.left_range_cm) ? MODE_OBS_R : MODE_OBS_L;
      end else if (item.right_range_cm < cfg.side_limit_cm) begin
         side_mode = MODE_OBS_R;
      end else begin
         side_mode = MODE_NAV;
      end
      if (close_front) begin
         front_mode = MODE_MID_CLOSE;
      end else if (item.middle_range_cm < cfg.middle_far_cm) begin
         front_mode = MODE_MID_FAR;
      end else begin
         front_mode = side_mode;
      end
   end

   always_comb begin
      mode_in                = mode_ff;
      pause_start_in         = pause_start_ff;
      cmd.motor_dir          = DIR_STOP;
      cmd.motor_speed_centi  = 8'd0;
      cmd.steer_deg          = 7'sd0;
      unique case (mode_ff)
         MODE_INIT: begin
            mode_in = MODE_WAIT;
         end
         MODE_WAIT: begin
            if (!stop_req) begin
               mode_in = MODE_NAV;
            end
         end
         MODE_NAV: begin
            mode_in               = bump ? MODE_MID_CLOSE : front_mode;
            cmd.motor_dir         = DIR_FWD;
            cmd.motor_speed_centi = nav_in.speed_centi;
            cmd.steer_deg         = nav_in.steer_deg;
            if (stop_req) begin
               mode_in = MODE_WAIT;
            end
         end
         MODE_OBS_R, MODE_OBS_L: begin
            mode_in               = (close_front || bump) ? MODE_MID_CLOSE : side_mode;
            cmd.motor_dir         = DIR_FWD;
            cmd.motor_speed_centi = SPEED_OBS;
            cmd.steer_deg         = (mode_ff == MODE_OBS_R) ? -$signed({1'b0, avoid})
                                                            : $signed({1'b0, avoid});
            if (stop_req) begin
               mode_in = MODE_WAIT;
            end
         end
         MODE_MID_FAR: begin
            mode_in               = bump ? MODE_MID_CLOSE : front_mode;
            cmd.motor_dir         = DIR_FWD;
            cmd.motor_speed_centi = SPEED_OBS;
            cmd.steer_deg         = $signed({1'b0, avoid});
            if (stop_req) begin
               mode_in = MODE_WAIT;
            end
         end
         MODE_MID_CLOSE: begin
            mode_in = front_mode;
            if (item.rear_range_cm >= cfg.reverse_limit_cm) begin
               cmd.motor_dir         = DIR_REV;
               cmd.motor_speed_centi = SPEED_REV;
            end
            if (front_mode != MODE_MID_CLOSE) begin
               mode_in        = MODE_PAUSE;
               pause_start_in = item.tick_count;
            end
            if (stop_req) begin
               mode_in = MODE_WAIT;
            end
         end
         MODE_PAUSE: begin
            if (pause_done) begin
               mode_in = front_mode;
            end
         end
      endcase
      cmd.mode_now = mode_in;
   end

endmodule

// ===== rtl/core/obstacle_avoid_nav_fsm_unit.sv =====
// Top level of the obstacle-avoiding navigation controller: channels, settings and pipeline.
//
// Each request carries one control-tick snapshot: go flag, tick number, four
// range readings, two active-low bumpers, heading error and waypoint distance.
// For every request the block returns exactly one response with the motor
// direction, speed, steer angle and the navigation mode after that tick.
// Requests arrive on the req_ stream and responses leave on the rsp_ stream;
// a request or response moves when tvalid and tready are both high.
// The csr_ port writes one of eight settings per cycle; write it only while
// no request is in flight. Indexes of eight and above are ignored.
// A request accepted into the input stage is registered there, its decision is
// made by the mode logic from that stage and the response register takes it
// when the input stage advances. Throughput is one request per cycle while the
// receiver keeps up, set by the single input stage and the response register.
// When the receiver stalls, the response register holds its response and the
// input stage keeps one more request; req_tready falls only when both are full.
// Reset is synchronous: it empties both stages, returns the mode to init,
// clears the pause start tick and loads the default settings.
module obstacle_avoid_nav_fsm_unit (
   input  logic                               clock,
   input  logic                               reset,
   // tdata, lowest bit up: go_enable, tick_count, left_range_cm, right_range_cm,
   // middle_range_cm, rear_range_cm, left_bumper_open, right_bumper_open,
   // heading_error_cdeg, waypoint_distance_dm, zero fill
   input  logic [obav_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata, lowest bit up: motor_dir, motor_speed_centi, steer_deg, mode_now, zero fill
   output logic [obav_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wr_en,
   input  logic [3:0]                         csr_index,
   input  logic [obav_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import obav_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           s1_valid_ff, s1_valid_in;
   req_type        s1_item_ff;
   req_type        req_item;
   logic           rsp_valid_ff, rsp_valid_in;
   cmd_type        rsp_cmd_ff;
   cmd_type        cmd;
   nav_steer_type  nav_steer;
   logic           req_fire, adv_en;

   // Settings registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STEER_THRESHOLD: cfg_in.side_limit_cm         = csr_wdata[9:0];
            CSR_MIDDLE_FAR:      cfg_in.middle_far_cm         = csr_wdata[9:0];
            CSR_MIDDLE_CLOSE:    cfg_in.middle_close_cm       = csr_wdata[9:0];
            CSR_REVERSE_LIMIT:   cfg_in.reverse_limit_cm      = csr_wdata[9:0];
            CSR_PAUSE_TICKS:     cfg_in.pause_ticks           = csr_wdata[15:0];
            CSR_ARRIVE_DISTANCE: cfg_in.arrive_distance_dm    = csr_wdata[15:0];
            CSR_HEADING_DB:      cfg_in.heading_deadband_cdeg = csr_wdata[14:0];
            CSR_AVOID_STEER:     cfg_in.avoid_steer_deg       = csr_wdata[5:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.side_limit_cm         <= 10'd100;
         cfg_ff.middle_far_cm         <= 10'd75;
         cfg_ff.middle_close_cm       <= 10'd35;
         cfg_ff.reverse_limit_cm      <= 10'd35;
         cfg_ff.pause_ticks           <= 16'd50;
         cfg_ff.arrive_distance_dm    <= 16'd100;
         cfg_ff.heading_deadband_cdeg <= 15'd200;
         cfg_ff.avoid_steer_deg       <= 6'd25;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the request word.
   assign req_item.go_enable            = req_tdata[0];
   assign req_item.tick_count           = req_tdata[32:1];
   assign req_item.left_range_cm        = req_tdata[42:33];
   assign req_item.right_range_cm       = req_tdata[52:43];
   assign req_item.middle_range_cm      = req_tdata[62:53];
   assign req_item.rear_range_cm        = req_tdata[72:63];
   assign req_item.left_bumper_open     = req_tdata[73];
   assign req_item.right_bumper_open    = req_tdata[74];
   assign req_item.heading_error_cdeg   = req_tdata[90:75];
   assign req_item.waypoint_distance_dm = req_tdata[106:91];

   // The input stage advances whenever the response register is free or drains.
   assign adv_en      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || adv_en;
   assign req_fire    = req_tvalid && req_tready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !adv_en);
   assign rsp_valid_in = adv_en || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (adv_en) begin
         rsp_cmd_ff <= cmd;
      end
   end

   obav_steer u_steer (
      .heading_error_cdeg    (s1_item_ff.heading_error_cdeg),
      .heading_deadband_cdeg (cfg_ff.heading_deadband_cdeg),
      .nav_out               (nav_steer)
   );

   obav_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .adv_en (adv_en),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .nav_in (nav_steer),
      .cmd    (cmd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_cmd_ff.mode_now, rsp_cmd_ff.steer_deg,
                        rsp_cmd_ff.motor_speed_centi, rsp_cmd_ff.motor_dir};

   // A request in the input stage always leaves the state machine out of init.
   a_leave_init: assert property (@(posedge clock) disable iff (reset)
      adv_en |=> (cmd.mode_now != MODE_INIT))
      else $error("mode returned to init after a request");

   // A stopped motor reports zero speed.
   a_stop_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cmd_ff.motor_dir == DIR_STOP) |-> (rsp_cmd_ff.motor_speed_centi == 8'd0))
      else $error("nonzero speed with motor stopped");

   // A response is loaded exactly when the input stage advances.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      adv_en |=> rsp_valid_ff)
      else $error("advanced request produced no response");

endmodule

// ===== test/obstacle_avoid_nav_fsm_unit_test.sv =====
// Self-checking bench for the obstacle-avoiding navigation controller, with its own mode predictor.
module obstacle_avoid_nav_fsm_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import obav_pkg::*;

   // Run shape. The directed part runs on reset settings; every later phase first
   // writes a new set of registers while the block is empty, then streams random
   // sensor snapshots.
   localparam int RANDOM_PHASES    = 7;
   localparam int ITEMS_PER_PHASE  = 132;
   localparam int PHASE_FLOOR      = 0;   // every register at zero
   localparam int PHASE_CEILING    = 1;   // every register at its widest value
   localparam int PRESSURE_PHASE   = 2;   // the receiver holds off once in this phase
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES    = 4;   // room for both stages to empty, plus margin
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int REPORT_LIMIT     = 10;

   // Arithmetic of the controller.
   localparam int HEADING_MAX     = 18000;
   localparam int RANGE_MAX       = 1023;
   localparam int DIST_MAX        = 65535;
   localparam int CDEG_PER_STEER  = 80;
   localparam int NAV_FULL_SPEED  = 200;
   localparam int NAV_SPEED_SPAN  = 90;
   localparam int STEER_LIMIT     = int'(STEER_MAX_DEG);
   localparam int CLEAR_CM        = 500;

   // Register indexes from eight up are not decoded by the block.
   localparam logic [3:0] CSR_INDEX_FIRST_UNUSED = 4'd8;

   // Predicts one motor command per accepted request and checks the responses
   // against the predictions in order.
   class nav_command_ledger;
      cfg_type      cfg;
      nav_mode_type mode_now;
      logic [31:0]  pause_from;
      cmd_type      owed_cmds[$];
      int           mismatches;
      int           checked;
      logic [7:0]   modes_seen;

      function new();
         cfg.side_limit_cm         = 10'd100;
         cfg.middle_far_cm         = 10'd75;
         cfg.middle_close_cm       = 10'd35;
         cfg.reverse_limit_cm      = 10'd35;
         cfg.pause_ticks           = 16'd50;
         cfg.arrive_distance_dm    = 16'd100;
         cfg.heading_deadband_cdeg = 15'd200;
         cfg.avoid_steer_deg       = 6'd25;
         mode_now   = MODE_INIT;
         pause_from = '0;
         mismatches = 0;
         checked    = 0;
         modes_seen = '0;
      endfunction

      function void write_setting(logic [3:0] index, logic [15:0] value);
         case (index)
            CSR_STEER_THRESHOLD: cfg.side_limit_cm         = value[9:0];
            CSR_MIDDLE_FAR:      cfg.middle_far_cm         = value[9:0];
            CSR_MIDDLE_CLOSE:    cfg.middle_close_cm       = value[9:0];
            CSR_REVERSE_LIMIT:   cfg.reverse_limit_cm      = value[9:0];
            CSR_PAUSE_TICKS:     cfg.pause_ticks           = value;
            CSR_ARRIVE_DISTANCE: cfg.arrive_distance_dm    = value;
            CSR_HEADING_DB:      cfg.heading_deadband_cdeg = value[14:0];
            CSR_AVOID_STEER:     cfg.avoid_steer_deg       = value[5:0];
            default: ;
         endcase
      endfunction

      function nav_mode_type side_mode(logic [9:0] left, logic [9:0] right);
         if (left < cfg.side_limit_cm) begin
            if (right <= left) return MODE_OBS_R;
            return MODE_OBS_L;
         end
         if (right < cfg.side_limit_cm) return MODE_OBS_R;
         return MODE_NAV;
      endfunction

      function nav_mode_type front_mode(nav_mode_type fallback, logic [9:0] middle);
         if (middle < cfg.middle_close_cm) return MODE_MID_CLOSE;
         if (middle < cfg.middle_far_cm) return MODE_MID_FAR;
         return fallback;
      endfunction

      function void note_snapshot(req_type s);
         cmd_type      c;
         nav_mode_type next;
         nav_mode_type sides;
         logic         bumped;
         logic         stopping;
         logic [31:0]  pause_end;
         int           heading;
         int           magnitude;
         int           steer;
         int           steer_mag;
         int           avoid;
         bumped   = !s.left_bumper_open || !s.right_bumper_open;
         stopping = !s.go_enable || (s.waypoint_distance_dm < cfg.arrive_distance_dm);
         heading  = $signed(s.heading_error_cdeg);
         avoid    = (cfg.avoid_steer_deg > STEER_MAX_DEG) ? STEER_LIMIT
                                                          : int'(cfg.avoid_steer_deg);
         sides    = side_mode(s.left_range_cm, s.right_range_cm);
         c.motor_dir         = DIR_STOP;
         c.motor_speed_centi = '0;
         steer = 0;
         next  = mode_now;
         case (mode_now)
            MODE_INIT: next = MODE_WAIT;
            MODE_WAIT: if (!stopping) next = MODE_NAV;
            MODE_NAV: begin
               magnitude = (heading < 0) ? -heading : heading;
               next = front_mode(sides, s.middle_range_cm);
               if (bumped) next = MODE_MID_CLOSE;
               // Integer division truncates toward zero, as the steering needs.
               if (magnitude > int'(cfg.heading_deadband_cdeg)) steer = heading / CDEG_PER_STEER;
               if (steer > STEER_LIMIT) steer = STEER_LIMIT;
               if (steer < -STEER_LIMIT) steer = -STEER_LIMIT;
               steer_mag = (steer < 0) ? -steer : steer;
               c.motor_dir         = DIR_FWD;
               c.motor_speed_centi =
                  8'((NAV_FULL_SPEED * (NAV_SPEED_SPAN - steer_mag)) / NAV_SPEED_SPAN);
               if (stopping) next = MODE_WAIT;
            end
            MODE_OBS_R, MODE_OBS_L: begin
               next = sides;
               if (s.middle_range_cm < cfg.middle_close_cm || bumped) next = MODE_MID_CLOSE;
               c.motor_dir         = DIR_FWD;
               c.motor_speed_centi = SPEED_OBS;
               steer = (mode_now == MODE_OBS_R) ? -avoid : avoid;
               if (stopping) next = MODE_WAIT;
            end
            MODE_MID_FAR: begin
               next = front_mode(sides, s.middle_range_cm);
               if (bumped) next = MODE_MID_CLOSE;
               c.motor_dir         = DIR_FWD;
               c.motor_speed_centi = SPEED_OBS;
               steer = avoid;
               if (stopping) next = MODE_WAIT;
            end
            MODE_MID_CLOSE: begin
               next = front_mode(sides, s.middle_range_cm);
               if (s.rear_range_cm >= cfg.reverse_limit_cm) begin
                  c.motor_dir         = DIR_REV;
                  c.motor_speed_centi = SPEED_REV;
               end
               // The pause start is taken even when a stop then overrides the mode.
               if (next != MODE_MID_CLOSE) begin
                  next       = MODE_PAUSE;
                  pause_from = s.tick_count;
               end
               if (stopping) next = MODE_WAIT;
            end
            default: begin
               // The end of the pause wraps at 32 bits; the compare is unsigned.
               pause_end = pause_from + 32'(cfg.pause_ticks);
               if (s.tick_count > pause_end) next = front_mode(sides, s.middle_range_cm);
            end
         endcase
         mode_now    = next;
         c.steer_deg = 7'(steer);
         c.mode_now  = next;
         modes_seen[next] = 1'b1;
         owed_cmds.push_back(c);
      endfunction

      function void check_command(logic [RSP_DATA_W-1:0] data);
         cmd_type got;
         cmd_type want;
         got.motor_dir         = motor_dir_type'(data[1:0]);
         got.motor_speed_centi = data[9:2];
         got.steer_deg         = data[16:10];
         got.mode_now          = nav_mode_type'(data[19:17]);
         if (owed_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Response with no request pending: dir %0d speed %0d steer %0d mode %0d",
                        got.motor_dir, got.motor_speed_centi, $signed(got.steer_deg),
                        got.mode_now);
            return;
         end
         want = owed_cmds.pop_front();
         checked++;
         if (got.motor_dir !== want.motor_dir
             || got.motor_speed_centi !== want.motor_speed_centi
             || got.steer_deg !== want.steer_deg
             || got.mode_now !== want.mode_now) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Command %0d: expected dir %0d speed %0d steer %0d mode %0d, %s %0d %0d %0d %0d",
                        checked, want.motor_dir, want.motor_speed_centi,
                        $signed(want.steer_deg), want.mode_now, "got",
                        got.motor_dir, got.motor_speed_centi, $signed(got.steer_deg),
                        got.mode_now);
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en  = 1'b0;
   logic [3:0]            csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // The snapshot now on the request bus, kept in step with req_tdata.
   req_type           offered = '0;
   nav_command_ledger ledger  = new();
   logic [31:0]       tick_now = '0;
   bit                idling_on = 1'b1;
   bit                hold_off_due = 1'b0;
   int                requests_seen = 0;
   int                settings_used = 1;
   int                quiet_cycles = 0;

   obstacle_avoid_nav_fsm_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Both channels are sampled at the edge that moves them. The response is
   // checked before the new request is noted, so a stray response cannot hide
   // behind a prediction made in the same cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_command(rsp_tdata);
      if (!reset && req_tvalid && req_tready) begin
         ledger.note_snapshot(offered);
         requests_seen++;
      end
   end

   // Cycles in a row in which neither channel moved anything.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Timeout: nothing moved on either channel for %0d cycles", WATCHDOG_LIMIT);
      $display("** obstacle_avoid_nav_fsm_unit: FAILED **");
      $finish;
   end

   // Receiver: random stalls, and once a long hold-off so that the response
   // register and the input stage both fill and the block drops req_tready
   // while the sender keeps offering.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_off_due = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // tdata, lowest bit up: go_enable, tick_count, left, right, middle and rear
   // ranges, left and right bumpers, heading error, waypoint distance, zero fill.
   function automatic logic [REQ_DATA_W-1:0] pack_snapshot(req_type s);
      return REQ_DATA_W'({s.waypoint_distance_dm, s.heading_error_cdeg,
                          s.right_bumper_open, s.left_bumper_open,
                          s.rear_range_cm, s.middle_range_cm,
                          s.right_range_cm, s.left_range_cm,
                          s.tick_count, s.go_enable});
   endfunction

   function automatic req_type snap(bit go, logic [31:0] tick, int left, int right,
                                    int middle, int rear, bit left_open, bit right_open,
                                    int heading, int goal_dm);
      req_type s;
      s.go_enable            = go;
      s.tick_count           = tick;
      s.left_range_cm        = 10'(left);
      s.right_range_cm       = 10'(right);
      s.middle_range_cm      = 10'(middle);
      s.rear_range_cm        = 10'(rear);
      s.left_bumper_open     = left_open;
      s.right_bumper_open    = right_open;
      s.heading_error_cdeg   = 16'(heading);
      s.waypoint_distance_dm = 16'(goal_dm);
      return s;
   endfunction

   // A range either just around a limit, anywhere, or clear of it.
   function automatic logic [9:0] range_near(logic [9:0] limit);
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, RANGE_MAX);
         1, 2:    v = int'(limit) + $urandom_range(0, 6) - 3;
         default: v = $urandom_range(int'(limit), RANGE_MAX);
      endcase
      if (v < 0) v = 0;
      if (v > RANGE_MAX) v = RANGE_MAX;
      return 10'(v);
   endfunction

   // Mostly plausible driving: the tick advances by one, the car is allowed to
   // go and is far from the waypoint, and the ranges sit around the current
   // limits. The rest is unshaped noise, jumps of the tick and wrap-arounds.
   function automatic req_type random_snapshot();
      req_type s;
      cfg_type k;
      int      heading;
      int      goal_dm;
      int      pick;
      k    = ledger.cfg;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         return snap(1'($urandom_range(0, 1)), $urandom, $urandom_range(0, RANGE_MAX),
                     $urandom_range(0, RANGE_MAX), $urandom_range(0, RANGE_MAX),
                     $urandom_range(0, RANGE_MAX), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 2 * HEADING_MAX) - HEADING_MAX,
                     $urandom_range(0, DIST_MAX));
      if (pick < 14) tick_now = $urandom;
      else if (pick < 15) tick_now = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else tick_now = tick_now + 32'd1;
      case ($urandom_range(0, 5))
         0:       heading = int'(k.heading_deadband_cdeg) + $urandom_range(0, 2) - 1;
         1:       heading = HEADING_MAX;
         2:       heading = $urandom_range(1, 225) * CDEG_PER_STEER + $urandom_range(0, 2) - 1;
         default: heading = $urandom_range(0, HEADING_MAX);
      endcase
      if (heading > HEADING_MAX) heading = HEADING_MAX;
      if (heading < 0) heading = 0;
      if ($urandom_range(0, 1) == 1) heading = -heading;
      if ($urandom_range(0, 9) != 0)
         goal_dm = int'(k.arrive_distance_dm)
                   + $urandom_range(0, DIST_MAX - int'(k.arrive_distance_dm));
      else
         goal_dm = $urandom_range(0, DIST_MAX);
      return snap($urandom_range(0, 19) != 0, tick_now,
                  int'(range_near(k.side_limit_cm)), int'(range_near(k.side_limit_cm)),
                  int'(range_near(($urandom_range(0, 1) == 1) ? k.middle_far_cm
                                                              : k.middle_close_cm)),
                  int'(range_near(k.reverse_limit_cm)),
                  $urandom_range(0, 24) != 0, $urandom_range(0, 24) != 0,
                  heading, goal_dm);
   endfunction

   // Offers one snapshot and returns at the edge where the request is taken.
   // A random gap may come first; tvalid is lowered and raised in different cycles.
   task automatic offer(req_type s);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      offered    <= s;
      req_tdata  <= pack_snapshot(s);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every predicted command has come back and
   // the pipeline has had time to empty.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ledger.owed_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write per cycle; the enable stays high across a burst.
   task automatic write_csr(logic [3:0] index, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      ledger.write_setting(index, value);
   endtask

   task automatic write_every(logic [15:0] value);
      write_csr(CSR_STEER_THRESHOLD, value);
      write_csr(CSR_MIDDLE_FAR, value);
      write_csr(CSR_MIDDLE_CLOSE, value);
      write_csr(CSR_REVERSE_LIMIT, value);
      write_csr(CSR_PAUSE_TICKS, value);
      write_csr(CSR_ARRIVE_DISTANCE, value);
      write_csr(CSR_HEADING_DB, value);
      write_csr(CSR_AVOID_STEER, value);
   endtask

   // The floor and ceiling phases set every register to its extreme; the
   // ceiling puts the deadband above the heading range and the avoidance angle
   // above the steer limit. Later phases pick settings at random, with short
   // pauses so that the pause mode is left often.
   task automatic program_phase(int phase);
      case (phase)
         PHASE_FLOOR:   write_every(16'h0000);
         PHASE_CEILING: write_every(16'hFFFF);
         default: begin
            write_csr(CSR_STEER_THRESHOLD, 16'($urandom_range(0, RANGE_MAX)));
            write_csr(CSR_MIDDLE_FAR, 16'($urandom_range(0, RANGE_MAX)));
            write_csr(CSR_MIDDLE_CLOSE, 16'($urandom_range(0, 400)));
            write_csr(CSR_REVERSE_LIMIT, 16'($urandom_range(0, RANGE_MAX)));
            write_csr(CSR_PAUSE_TICKS, 16'($urandom_range(0, 40)));
            write_csr(CSR_ARRIVE_DISTANCE, 16'($urandom_range(0, 3000)));
            write_csr(CSR_HEADING_DB, 16'($urandom_range(0, 20000)));
            write_csr(CSR_AVOID_STEER, 16'($urandom_range(0, 63)));
         end
      endcase
      // An index the block does not decode must leave every setting alone.
      write_csr(CSR_INDEX_FIRST_UNUSED + 4'($urandom_range(0, 7)), 16'($urandom));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed walk on reset settings: through every mode, the field extremes,
      // the deadband edge, truncation toward zero, the steer clamp, both pause
      // boundaries with and without tick wrap-around, and the stop overrides.
      offer(snap(0, 32'd0, 0, 0, 0, 0, 0, 0, -18000, 0));
      offer(snap(0, 32'hFFFF_FFFF, 1023, 1023, 1023, 1023, 1, 1, 18000, 65535));
      offer(snap(1, 32'd100, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 100));
      offer(snap(1, 32'd101, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 200, 5000));
      offer(snap(1, 32'd102, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 201, 5000));
      offer(snap(1, 32'd103, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, -239, 5000));
      offer(snap(1, 32'd104, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, -18000, 5000));
      offer(snap(1, 32'd105, 50, 60, CLEAR_CM, CLEAR_CM, 1, 1, 3599, 5000));
      offer(snap(1, 32'd106, 40, 40, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd107, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd108, CLEAR_CM, CLEAR_CM, 50, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd109, CLEAR_CM, CLEAR_CM, 20, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd1000, CLEAR_CM, CLEAR_CM, CLEAR_CM, 35, 1, 1, 0, 5000));
      offer(snap(1, 32'd1050, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd1051, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd1052, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 0, 1, 0, 5000));
      offer(snap(1, 32'd1053, CLEAR_CM, CLEAR_CM, 10, 34, 1, 1, 0, 5000));
      offer(snap(0, 32'd1054, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd1055, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 99));
      offer(snap(1, 32'd1056, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd1057, 200, 50, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'd1058, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 0, 0, 5000));
      offer(snap(1, 32'hFFFF_FFF0, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'h0000_0022, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'h0000_0023, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 5000));
      offer(snap(1, 32'h0000_0024, CLEAR_CM, CLEAR_CM, CLEAR_CM, CLEAR_CM, 1, 1, 0, 99));
      tick_now = 32'h0000_0024;

      // Random phases. Settings change only once the block has emptied; the
      // last phase runs with both sides always ready.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         program_phase(phase);
         if (phase == RANDOM_PHASES - 1) idling_on = 1'b0;
         if (phase == PRESSURE_PHASE) hold_off_due = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) offer(random_snapshot());
      end
      drain();

      $display("Checked %0d motor commands from %0d requests over %0d register settings.",
               ledger.checked, requests_seen, settings_used);
      $display("Modes reached, one bit per mode from init up: %b; mismatches: %0d.",
               ledger.modes_seen, ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.owed_cmds.size() == 0) begin
         $display("** obstacle_avoid_nav_fsm_unit: PASSED **");
      end else begin
         $display("** obstacle_avoid_nav_fsm_unit: FAILED **");
      end
      $finish;
   end

endmodule
